// ===== design/kvt_pkg.sv =====
`default_nettype none
package kvt_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	// wide enough for both the slot field and the entry count
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_WRITE  = 2'd1,
		OP_PROBE  = 2'd2,
		OP_SLOT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_MISS  = 2'd2,
		ERR_RANGE = 2'd3
	} err_t;

	typedef struct packed {
		logic [IDX_W-1:0]      rd_addr;
		logic                  we_key;
		logic                  we_val;
		logic [IDX_W-1:0]      wr_addr;
		logic [KEY_BITS-1:0]   wr_key;
		logic [VALUE_BITS-1:0] wr_val;
	} mem_req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [KEY_BITS-1:0]   key;
		logic                  hit;
		logic                  inserted;
		err_t                  error;
		logic [CNT_W-1:0]      count;
		logic                  is_empty;
	} result_t;

endpackage
`default_nettype wire

// ===== design/kvt_store.sv =====
`default_nettype none
module kvt_store
	import kvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire mem_req_t              req,
	output logic [KEY_BITS-1:0]        key_rd,
	output logic [VALUE_BITS-1:0]      val_rd
);

	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we_key) begin
			key_mem[req.wr_addr] <= req.wr_key;
		end
		if (req.we_val) begin
			val_mem[req.wr_addr] <= req.wr_val;
		end
		key_rd <= key_mem[req.rd_addr];
		val_rd <= val_mem[req.rd_addr];
	end

endmodule
`default_nettype wire

// ===== design/kvt_seq.sv =====
`default_nettype none
module kvt_seq
	import kvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire op_t                   in_op,
	input  wire logic [KEY_BITS-1:0]   in_key,
	input  wire logic [VALUE_BITS-1:0] in_wv,
	input  wire logic [3:0]            in_slot,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output result_t                    res,
	output mem_req_t                   mem_req,
	input  wire logic [KEY_BITS-1:0]   key_rd,
	input  wire logic [VALUE_BITS-1:0] val_rd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SLOT,
		ST_SLOT_RD,
		ST_DONE
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wv_q;
	logic [3:0]            slot_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  cmp_v_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic [CNT_W-1:0]      count_q;
	logic [VALUE_BITS-1:0] rv_q;
	logic [KEY_BITS-1:0]   rk_q;
	logic                  hit_q;
	logic                  ins_q;
	err_t                  err_q;

	logic                  issue;
	logic                  match;
	logic                  miss;
	logic                  full;
	logic                  slot_ok;
	logic                  ins_now;
	logic                  upd_now;
	logic [VALUE_BITS-1:0] new_val;

	// scan is pipelined: address issued this cycle, compared the next
	always_comb begin
		issue   = (state_q == ST_SCAN) && (idx_q < count_q);
		match   = cmp_v_q && (key_rd == key_q);
		miss    = (state_q == ST_SCAN) && !issue && !match;
		full    = (count_q >= CNT_W'(ENTRIES));
		slot_ok = (CMP_W'(slot_q) < CMP_W'(count_q));
		ins_now = miss && (op_q != OP_PROBE) && !full;
		upd_now = (state_q == ST_SCAN) && match && (op_q == OP_WRITE);
		new_val = (op_q == OP_WRITE) ? wv_q : '0;

		mem_req.rd_addr = (state_q == ST_SLOT) ? IDX_W'(slot_q) : idx_q[IDX_W-1:0];
		mem_req.we_key  = ins_now;
		mem_req.we_val  = ins_now || upd_now;
		mem_req.wr_addr = ins_now ? count_q[IDX_W-1:0] : cmp_idx_q;
		mem_req.wr_key  = key_q;
		mem_req.wr_val  = new_val;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.value    = rv_q;
		res.key      = rk_q;
		res.hit      = hit_q;
		res.inserted = ins_q;
		res.error    = err_q;
		res.count    = count_q;
		res.is_empty = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cmp_v_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= in_op;
						key_q   <= in_key;
						wv_q    <= in_wv;
						slot_q  <= in_slot;
						idx_q   <= '0;
						cmp_v_q <= 1'b0;
						rv_q    <= '0;
						rk_q    <= '0;
						hit_q   <= 1'b0;
						ins_q   <= 1'b0;
						err_q   <= ERR_NONE;
						state_q <= (in_op == OP_SLOT) ? ST_SLOT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					cmp_v_q   <= issue;
					cmp_idx_q <= idx_q[IDX_W-1:0];
					if (match) begin
						hit_q   <= 1'b1;
						rv_q    <= (op_q == OP_WRITE) ? wv_q : val_rd;
						cmp_v_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (miss) begin
						priority if (op_q == OP_PROBE) begin
							err_q <= ERR_MISS;
						end else if (full) begin
							err_q <= ERR_FULL;
						end else begin
							ins_q   <= 1'b1;
							rv_q    <= new_val;
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_SLOT: begin
					if (slot_ok) begin
						state_q <= ST_SLOT_RD;
					end else begin
						err_q   <= ERR_RANGE;
						state_q <= ST_DONE;
					end
				end
				ST_SLOT_RD: begin
					rk_q    <= key_rd;
					rv_q    <= val_rd;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_now |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not bump entry count");

	a_insert_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.inserted |-> (res.error == ERR_NONE) && !res.hit)
		else $error("insert flagged together with hit or error");

	a_no_write_on_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we_key || mem_req.we_val) |-> (op_q != OP_PROBE) && (op_q != OP_SLOT))
		else $error("store written by a read-only request");

endmodule
`default_nettype wire

// ===== design/key_value_table_lookup_insert.sv =====
// Lookup, write and probe scan the entries in order and stop at the first hit, or after all
// N entries on a miss, N being the entry count; the single key compare walks the key memory
// one entry per cycle behind a registered read.
// Slot reads pass ST_SLOT and ST_SLOT_RD in range, ST_SLOT alone out of range. One request at a
// time: s_tready is low while busy and rises with tvalid once the previous beat has left.
// arst_n clears the entry count and the handshake state; table contents are not cleared.
`default_nettype none
module key_value_table_lookup_insert
	import kvt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // key[31:0], wr_value[63:32], slot[67:64], zero pad
	input  wire logic [1:0]  s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata    // value_out[31:0], key_out[63:32], hit[64],
	                                    // inserted[65], error[67:66], count[72:68],
	                                    // is_empty[73], zero pad
);

	mem_req_t              mem_req;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic                  res_valid;
	logic                  res_ready;
	result_t               res;
	logic                  m_valid_q;
	logic [79:0]           m_data_q;

	kvt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser)),
		.in_key    (KEY_BITS'(s_tdata[31:0])),
		.in_wv     (VALUE_BITS'(s_tdata[63:32])),
		.in_slot   (s_tdata[67:64]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.key_rd    (key_rd),
		.val_rd    (val_rd)
	);

	kvt_store u_store (
		.clk    (clk),
		.req    (mem_req),
		.key_rd (key_rd),
		.val_rd (val_rd)
	);

	// output register frees the sequencer as soon as the beat is parked here
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= {6'd0, res.is_empty, 5'(res.count), res.error,
				res.inserted, res.hit, 32'(res.key), 32'(res.value)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire
